FILE: sv/spi_seq_pkg.sv
// Package for the SPI EEPROM transfer sequencer: payload structs, action codes,
// device tables and the job descriptor passed between front and back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spi_seq_pkg;

	localparam int ADDR_BITS  = 17;
	localparam int SIZE_W     = ADDR_BITS + 1;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int NSTEPS     = 11;

	localparam logic [2:0] ACT_SELECT   = 3'd0;
	localparam logic [2:0] ACT_DESELECT = 3'd1;
	localparam logic [2:0] ACT_SEND     = 3'd2;
	localparam logic [2:0] ACT_CAPTURE  = 3'd3;
	localparam logic [2:0] ACT_WAIT     = 3'd4;

	localparam logic [7:0] CMD_READ   = 8'h03;
	localparam logic [7:0] CMD_WRITE  = 8'h02;
	localparam logic [7:0] CMD_WREN   = 8'h06;
	localparam logic [7:0] DUMMY_BYTE = 8'hAA;

	// address formats
	localparam logic [1:0] FMT_ONE   = 2'd0;
	localparam logic [1:0] FMT_NINTH = 2'd1;
	localparam logic [1:0] FMT_TWO   = 2'd2;
	localparam logic [1:0] FMT_THREE = 2'd3;

	typedef struct packed {
		logic                 kind;
		logic [ADDR_BITS-1:0] address;
		logic [7:0]           write_byte;
		logic                 last_of_request;
	} item_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] spi_byte;
		logic       last_action;
	} result_t;

	// One classified item: which groups of actions the back end plays out.
	typedef struct packed {
		logic                 is_read;
		logic [1:0]           fmt;
		logic                 do_open;
		logic                 do_data;
		logic                 do_close;
		logic [ADDR_BITS-1:0] addr;
		logic [7:0]           data;
	} job_t;

	function automatic logic [3:0] type_index(input logic [3:0] t);
		return (t > 4'd9) ? 4'd9 : t;
	endfunction

	function automatic logic [SIZE_W-1:0] dev_size(input logic [3:0] t);
		return SIZE_W'(256) << t;
	endfunction

	function automatic logic [8:0] page_mask(input logic [3:0] t);
		logic [8:0] m;
		case (t)
			4'd0, 4'd1, 4'd2, 4'd3: m = 9'd15;
			4'd4, 4'd5:             m = 9'd31;
			4'd6, 4'd7:             m = 9'd63;
			4'd8:                   m = 9'd127;
			default:                m = 9'd255;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] addr_fmt(input logic [3:0] t);
		logic [1:0] f;
		case (t)
			4'd0:    f = FMT_ONE;
			4'd1:    f = FMT_NINTH;
			4'd9:    f = FMT_THREE;
			default: f = FMT_TWO;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

FILE: sv/spi_seq_front.sv
// Front end: accepts input beats, tracks request state and the device type
// register, and turns each item into a job for the back end.
// Depends on spi_seq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spi_seq_front import spi_seq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire item_t item,
	input  wire logic  cfg_we,
	input  wire logic [3:0] cfg_data,
	output logic       job_push,
	output job_t       job
);

	logic                 in_req_q, open_q, drop_q, read_q;
	logic [ADDR_BITS-1:0] next_q;
	logic [3:0]           dev_q;

	logic                 start, rd, opn, drp, last;
	logic [ADDR_BITS-1:0] addr;
	logic [3:0]           t;
	logic [SIZE_W-1:0]    density, following;
	logic                 beyond, close_now;
	logic                 open_n, drop_n, in_req_n;
	logic [ADDR_BITS-1:0] next_n;
	logic                 pre_close, do_open, do_data;

	always_comb begin
		t        = type_index(dev_q);
		density  = dev_size(t);
		start    = !in_req_q;
		last     = item.last_of_request;
		rd       = start ? item.kind : read_q;
		addr     = start ? item.address : next_q;
		opn      = start ? 1'b0 : open_q;
		beyond   = SIZE_W'(addr) >= density;
		drp      = start ? beyond : drop_q;
		following = SIZE_W'(addr) + SIZE_W'(1);

		pre_close = 1'b0;
		do_open   = 1'b0;
		do_data   = 1'b0;
		close_now = 1'b0;
		open_n    = opn;
		drop_n    = drp;
		next_n    = addr;
		if (!drp) begin
			if (beyond) begin
				// device shrank under a running request: close and drop the rest
				pre_close = opn;
				open_n    = 1'b0;
				drop_n    = 1'b1;
			end else begin
				do_open   = !opn;
				do_data   = 1'b1;
				close_now = (following >= density) || last ||
					(!rd && ((following[8:0] & page_mask(t)) == 9'd0));
				drop_n    = following >= density;
				open_n    = !close_now;
				next_n    = following[ADDR_BITS-1:0];
			end
		end
		in_req_n = 1'b1;
		if (last) begin
			in_req_n = 1'b0;
			drop_n   = 1'b0;
		end

		job.is_read  = rd;
		job.fmt      = addr_fmt(t);
		job.do_open  = do_open;
		job.do_data  = do_data;
		job.do_close = pre_close || close_now;
		job.addr     = addr;
		job.data     = item.write_byte;
		job_push     = accept && (pre_close || do_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_req_q <= 1'b0;
			open_q   <= 1'b0;
			drop_q   <= 1'b0;
			read_q   <= 1'b0;
			next_q   <= '0;
			dev_q    <= 4'd0;
		end else begin
			if (cfg_we) begin
				dev_q <= cfg_data;
			end
			if (accept) begin
				in_req_q <= in_req_n;
				open_q   <= open_n;
				drop_q   <= drop_n;
				read_q   <= rd;
				next_q   <= next_n;
			end
		end
	end

`ifndef SYNTHESIS
	// an open transfer or a drop only lives inside a request
	a_state_in_req: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q || drop_q) |-> in_req_q)
		else $error("transfer open or dropping outside a request");
`endif

endmodule

`default_nettype wire

FILE: sv/spi_seq_fifo.sv
// Short job queue between front and back end, flop based.
// Depends on spi_seq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spi_seq_fifo import spi_seq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire job_t wdata,
	input  wire logic rd,
	output job_t      rdata,
	output logic      full,
	output logic      empty
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_wr, do_rd;

	assign full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH))
		else $error("job queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: sv/spi_seq_back.sv
// Back end: plays a job out as SPI actions, one result beat per cycle while pop is high.
// Depends on spi_seq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spi_seq_back import spi_seq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job_in,
	input  wire logic job_avail,
	output logic      job_take,
	input  wire logic pop,
	output logic      empty,
	output result_t   result
);

	localparam int ST_WSEL  = 0;
	localparam int ST_WREN  = 1;
	localparam int ST_WDES  = 2;
	localparam int ST_SEL   = 3;
	localparam int ST_CMD   = 4;
	localparam int ST_A2    = 5;
	localparam int ST_A1    = 6;
	localparam int ST_A0    = 7;
	localparam int ST_DATA  = 8;
	localparam int ST_DES   = 9;
	localparam int ST_WAIT  = 10;

	job_t              job_q;
	logic [NSTEPS-1:0] mask_q;
	logic [NSTEPS-1:0] cur, rest, load_mask;
	logic [23:0]       ax;
	logic [7:0]        cmd;
	logic              busy, fin;

	function automatic logic [NSTEPS-1:0] steps_of(input job_t j);
		logic [NSTEPS-1:0] m;
		m          = '0;
		m[ST_WSEL] = j.do_open && !j.is_read;
		m[ST_WREN] = j.do_open && !j.is_read;
		m[ST_WDES] = j.do_open && !j.is_read;
		m[ST_SEL]  = j.do_open;
		m[ST_CMD]  = j.do_open;
		m[ST_A2]   = j.do_open && (j.fmt == FMT_THREE);
		m[ST_A1]   = j.do_open && (j.fmt == FMT_TWO || j.fmt == FMT_THREE);
		m[ST_A0]   = j.do_open;
		m[ST_DATA] = j.do_data;
		m[ST_DES]  = j.do_close;
		m[ST_WAIT] = j.do_close && !j.is_read;
		return m;
	endfunction

	always_comb begin
		busy      = |mask_q;
		cur       = mask_q & (~mask_q + NSTEPS'(1));
		rest      = mask_q & ~cur;
		fin       = rest == '0;
		load_mask = steps_of(job_in);
		job_take  = job_avail && (!busy || (pop && fin));
		empty     = !busy;

		ax  = 24'(job_q.addr);
		cmd = job_q.is_read ? CMD_READ : CMD_WRITE;
		if (job_q.fmt == FMT_NINTH) begin
			cmd = cmd | {4'd0, ax[8], 3'd0};
		end

		result.action      = ACT_SEND;
		result.spi_byte    = 8'd0;
		result.last_action = fin;
		case (1'b1)
			cur[ST_WSEL], cur[ST_SEL]: result.action = ACT_SELECT;
			cur[ST_WREN]:              result.spi_byte = CMD_WREN;
			cur[ST_WDES], cur[ST_DES]: result.action = ACT_DESELECT;
			cur[ST_CMD]:               result.spi_byte = cmd;
			cur[ST_A2]:                result.spi_byte = ax[23:16];
			cur[ST_A1]:                result.spi_byte = ax[15:8];
			cur[ST_A0]:                result.spi_byte = ax[7:0];
			cur[ST_DATA]: begin
				result.action   = job_q.is_read ? ACT_CAPTURE : ACT_SEND;
				result.spi_byte = job_q.is_read ? DUMMY_BYTE : job_q.data;
			end
			cur[ST_WAIT]:              result.action = ACT_WAIT;
			default:                   result.action = ACT_SEND;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (job_take) begin
			mask_q <= load_mask;
		end else if (pop && busy) begin
			mask_q <= rest;
		end
	end

`ifndef SYNTHESIS
	// a popped beat that is not the last of its item leaves more to show
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last_action) |=> !empty)
		else $error("actions of an item lost");
	// select for the data transfer always comes with its command
	a_sel_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q[ST_SEL] |-> (mask_q[ST_CMD] && mask_q[ST_A0]))
		else $error("select without command");
	// write enable goes out as a whole transfer
	a_wren_group: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q[ST_WSEL] |-> (mask_q[ST_WREN] && mask_q[ST_WDES]))
		else $error("broken write enable transfer");
`endif

endmodule

`default_nettype wire

FILE: sv/spi_eeprom_transfer_sequencer.sv
// SPI EEPROM transfer sequencer: top level.
// Turns request bytes into select, deselect, send, capture and wait actions.
// Input channel: push/full with one item struct per beat. An item is taken
// whenever the job queue has room; the front end classifies one item a cycle.
// Result channel: empty/pop. The oldest action sits on result while empty is
// low; pop takes it. Each item yields 0 to 11 actions; last_action marks the
// final one of an item, and items with no actions leave nothing on the port.
// Configuration: cfg_valid/cfg_ready carry device_type, always ready; write
// only while the block is idle.
// Timing: an accepted item is registered in the job queue, then loaded into
// the back end's step mask when the back end is idle; its first action shows
// from that mask and can be popped while shown. Rate: the back end shows one
// action per cycle while pop is high, so an item takes as many pops as it has
// actions (one for a plain data byte, up to eleven when a write page opens and
// closes); the front end keeps taking items into the four-entry job queue meanwhile.
// When the receiver stalls the current action holds and the queue fills, then
// full rises. Reset empties the queue, drops any request in flight and sets
// device_type to zero.
// Depends on spi_seq_pkg, spi_seq_front, spi_seq_fifo, spi_seq_back.
`timescale 1ns / 1ps
`default_nettype none

module spi_eeprom_transfer_sequencer import spi_seq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire item_t      item,
	output logic            empty,
	input  wire logic       pop,
	output result_t         result,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data
);

	job_t fr_job, q_job;
	logic fr_push, q_empty, q_full, bk_take, accept;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	spi_seq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.job_push (fr_push),
		.job      (fr_job)
	);

	spi_seq_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fr_push),
		.wdata  (fr_job),
		.rd     (bk_take),
		.rdata  (q_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	spi_seq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_in    (q_job),
		.job_avail (!q_empty),
		.job_take  (bk_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for spi_eeprom_transfer_sequencer: EEPROM byte requests go in on push/full,
// and every SPI action popped is checked against a local model of the sequencer.
// Depends on spi_seq_pkg and spi_eeprom_transfer_sequencer.
`timescale 1ns / 1ps

module tb;
	import spi_seq_pkg::*;

	localparam logic KIND_WRITE    = 1'b0;
	localparam logic KIND_READ     = 1'b1;
	localparam int   RANDOM_ITEMS  = 200;
	localparam int   PHASE_ITEMS   = 25;
	localparam int   SETTLE_CYCLES = 16;
	localparam int   MAX_GAP       = 13;
	localparam int   CYCLE_LIMIT   = 600000;
	localparam int   PRINT_LIMIT   = 40;
	// device types for the first random phases, taken from the low nibble upwards
	localparam logic [7:0][3:0] PHASE_TYPES = {4'd12, 4'd8, 4'd5, 4'd1, 4'd15, 4'd9, 4'd0, 4'd3};

	typedef struct packed {
		logic       retype;
		logic [3:0] new_type;
		item_t      it;
		logic       typed;
		logic [2:0] n_typed;
		logic [59:0] typed_acts;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic       full;
	item_t      item      = '0;
	logic       empty;
	logic       pop       = 1'b0;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data  = 4'd0;

	// sequencer state as predicted
	logic                 seq_in_req = 1'b0;
	logic                 seq_open   = 1'b0;
	logic                 seq_skip   = 1'b0;
	logic                 seq_read   = 1'b0;
	logic [ADDR_BITS-1:0] seq_addr   = '0;
	logic [3:0]           seq_type   = 4'd0;

	result_t  item_actions[$];
	result_t  expected_actions[$];
	dir_row_t directed[$];
	int       errors      = 0;
	int       productive  = 0;
	int       cycle_count = 0;
	int       send_run    = 0;

	spi_eeprom_transfer_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned page_size(input int unsigned t);
		int unsigned p;
		case (t)
			0, 1, 2, 3: p = 16;
			4, 5:       p = 32;
			6, 7:       p = 64;
			8:          p = 128;
			default:    p = 256;
		endcase
		return p;
	endfunction

	function automatic result_t action_of(input logic [2:0] a, input logic [7:0] b,
			input logic last);
		result_t r;
		r.action = a;
		r.spi_byte = b;
		r.last_action = last;
		return r;
	endfunction

	function automatic void note_action(input logic [2:0] a, input logic [7:0] b);
		item_actions.push_back(action_of(a, b, 1'b0));
	endfunction

	// deselect; a write also waits out its programming cycle
	function automatic void end_transfer();
		if (seq_open) begin
			note_action(ACT_DESELECT, 8'h00);
			if (!seq_read)
				note_action(ACT_WAIT, 8'h00);
			seq_open = 1'b0;
		end
	endfunction

	function automatic void predict_actions(input item_t it);
		int unsigned t, density, page, following;
		logic [7:0]  cmd;
		result_t     r;
		t = (seq_type > 4'd9) ? 9 : seq_type;
		density = 32'd256 << t;
		page = page_size(t);
		item_actions.delete();
		if (!seq_in_req) begin
			seq_in_req = 1'b1;
			seq_read = it.kind;
			seq_addr = it.address;
			seq_open = 1'b0;
			seq_skip = (seq_addr >= density);
		end
		if (!seq_skip) begin
			if (seq_addr >= density) begin
				// type shrank under a running request
				end_transfer();
				seq_skip = 1'b1;
			end else begin
				following = seq_addr + 1;
				if (!seq_open) begin
					if (!seq_read) begin
						note_action(ACT_SELECT, 8'h00);
						note_action(ACT_SEND, CMD_WREN);
						note_action(ACT_DESELECT, 8'h00);
					end
					note_action(ACT_SELECT, 8'h00);
					cmd = seq_read ? CMD_READ : CMD_WRITE;
					// the 4Kbit part carries address bit 8 in the command
					if (t == 1)
						cmd[3] = seq_addr[8];
					note_action(ACT_SEND, cmd);
					if (t == 9)
						note_action(ACT_SEND, 8'(seq_addr >> 16));
					if (t >= 2)
						note_action(ACT_SEND, seq_addr[15:8]);
					note_action(ACT_SEND, seq_addr[7:0]);
					seq_open = 1'b1;
				end
				if (seq_read)
					note_action(ACT_CAPTURE, DUMMY_BYTE);
				else
					note_action(ACT_SEND, it.write_byte);
				if (following >= density) begin
					end_transfer();
					seq_skip = 1'b1;
				end else if (it.last_of_request || (!seq_read && (following % page) == 0)) begin
					end_transfer();
				end
				seq_addr = following[ADDR_BITS-1:0];
			end
		end
		if (it.last_of_request) begin
			seq_in_req = 1'b0;
			seq_skip = 1'b0;
		end
		if (item_actions.size() > 0) begin
			r = item_actions.pop_back();
			r.last_action = 1'b1;
			item_actions.push_back(r);
		end
	endfunction

	function automatic void add_row(input logic retype, input logic [3:0] ty, input logic kind,
			input logic [ADDR_BITS-1:0] addr, input logic [7:0] data, input logic last,
			input logic typed, input logic [2:0] n, input logic [59:0] acts);
		dir_row_t row;
		row.retype = retype;
		row.new_type = ty;
		row.it.kind = kind;
		row.it.address = addr;
		row.it.write_byte = data;
		row.it.last_of_request = last;
		row.typed = typed;
		row.n_typed = n;
		row.typed_acts = acts;
		directed.push_back(row);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic draw_wait(inout int run, output int cycles);
		if (run > 0) begin
			run--;
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, MAX_GAP);
			if ($urandom_range(0, 15) == 0)
				run = $urandom_range(8, 40);
		end
	endtask

	task automatic drive_item(input item_t it, input logic typed, input logic [2:0] n,
			input logic [59:0] acts);
		int gap;
		draw_wait(send_run, gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_actions(it);
		if (item_actions.size() > 0)
			productive++;
		if (typed) begin
			for (int i = 0; i < n; i++)
				expected_actions.push_back(acts[59 - 12 * i -: 12]);
		end else begin
			foreach (item_actions[i])
				expected_actions.push_back(item_actions[i]);
		end
	endtask

	// hold the sender until every action is out and the front end has gone quiet
	task automatic drain_block();
		push <= 1'b0;
		while (expected_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_type(input logic [3:0] v);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		seq_type = v;
	endtask

	task automatic random_request();
		int unsigned t, density, page, start, len, pick;
		logic        kind;
		item_t       it;
		t = (seq_type > 4'd9) ? 9 : seq_type;
		density = 32'd256 << t;
		page = page_size(t);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// loose items with the last flag at random: breaks request framing
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				it = $bits(item_t)'($urandom);
				drive_item(it, 1'b0, 3'd0, '0);
			end
		end else begin
			if (pick < 55)
				start = $urandom_range(0, density - 1);
			else if (pick < 70)
				start = ($urandom_range(0, density - 1) & ~(page - 1)) + page
					- $urandom_range(1, 3);
			else if (pick < 82)
				start = density - $urandom_range(1, 4);
			else if (pick < 92)
				start = (density < 131072) ? $urandom_range(density, 131071)
					: $urandom_range(0, 131071);
			else
				start = $urandom_range(0, 131071);
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
			kind = 1'($urandom_range(0, 1));
			for (int i = 0; i < len; i++) begin
				// kind and address only count on the first beat; scramble the rest
				it.kind = (i == 0) ? kind : 1'($urandom);
				it.address = (i == 0) ? start[ADDR_BITS-1:0] : ADDR_BITS'($urandom);
				it.write_byte = 8'($urandom);
				it.last_of_request = (i == len - 1);
				drive_item(it, 1'b0, 3'd0, '0);
			end
		end
	endtask

	initial begin : receiver
		result_t want;
		int      wait_cycles;
		int      pop_run;
		pop_run = 0;
		@(posedge arst_n);
		forever begin
			draw_wait(pop_run, wait_cycles);
			if (wait_cycles > 0) begin
				pop <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			if (expected_actions.size() == 0) begin
				report_mismatch($sformatf("action %0d byte %02h with nothing expected",
					result.action, result.spi_byte));
			end else begin
				want = expected_actions.pop_front();
				if (result.action !== want.action)
					report_mismatch($sformatf("action %0d, expected %0d",
						result.action, want.action));
				if (result.spi_byte !== want.spi_byte)
					report_mismatch($sformatf("spi_byte %02h, expected %02h (action %0d)",
						result.spi_byte, want.spi_byte, want.action));
				if (result.last_action !== want.last_action)
					report_mismatch($sformatf("last_action %0d, expected %0d (action %0d)",
						result.last_action, want.last_action, want.action));
			end
		end
	end

	initial begin : stimulus
		dir_row_t row;
		int       phase;
		int       goal;
		// retype type kind        address    byte   last typed n  expected actions
		add_row(0, 4'd0, KIND_READ,  17'h00000, 8'h00, 1, 1, 5, {
			action_of(ACT_SELECT, 8'h00, 1'b0), action_of(ACT_SEND, CMD_READ, 1'b0),
			action_of(ACT_SEND, 8'h00, 1'b0), action_of(ACT_CAPTURE, DUMMY_BYTE, 1'b0),
			action_of(ACT_DESELECT, 8'h00, 1'b1)});
		add_row(0, 4'd0, KIND_WRITE, 17'h000FF, 8'hFF, 1, 0, 0, '0);
		// start beyond the device: whole request dropped
		add_row(0, 4'd0, KIND_WRITE, 17'h1FFFF, 8'h00, 0, 1, 0, '0);
		add_row(0, 4'd0, KIND_WRITE, 17'h00000, 8'h55, 1, 1, 0, '0);
		// run off the end of the device
		add_row(0, 4'd0, KIND_READ,  17'h000FE, 8'h00, 0, 0, 0, '0);
		add_row(0, 4'd0, KIND_WRITE, 17'h00000, 8'h00, 0, 0, 0, '0);
		add_row(0, 4'd0, KIND_READ,  17'h00000, 8'h00, 1, 1, 0, '0);
		// ninth address bit in the command, page split
		add_row(1, 4'd1, KIND_WRITE, 17'h0010E, 8'hA5, 0, 0, 0, '0);
		add_row(0, 4'd1, KIND_WRITE, 17'h00000, 8'h5A, 0, 0, 0, '0);
		add_row(0, 4'd1, KIND_WRITE, 17'h00000, 8'h0F, 1, 0, 0, '0);
		add_row(0, 4'd1, KIND_READ,  17'h00100, 8'h00, 1, 0, 0, '0);
		add_row(1, 4'd8, KIND_WRITE, 17'h0FFFF, 8'hC3, 1, 0, 0, '0);
		// shrink the device under an open write
		add_row(1, 4'd9, KIND_WRITE, 17'h18000, 8'h3C, 0, 0, 0, '0);
		add_row(1, 4'd8, KIND_WRITE, 17'h00000, 8'h99, 0, 0, 0, '0);
		add_row(0, 4'd8, KIND_WRITE, 17'h00000, 8'h66, 1, 1, 0, '0);
		// types above nine act as the largest part
		add_row(1, 4'd15, KIND_READ, 17'h1FFFF, 8'h00, 0, 0, 0, '0);
		add_row(0, 4'd15, KIND_READ, 17'h00000, 8'h00, 1, 1, 0, '0);
		add_row(1, 4'd10, KIND_WRITE, 17'h00000, 8'h00, 1, 0, 0, '0);
		add_row(1, 4'd4, KIND_READ,  17'h01000, 8'h00, 1, 1, 0, '0);
		add_row(0, 4'd4, KIND_WRITE, 17'h0001E, 8'h11, 0, 0, 0, '0);
		add_row(0, 4'd4, KIND_WRITE, 17'h00000, 8'h22, 0, 0, 0, '0);
		add_row(0, 4'd4, KIND_WRITE, 17'h00000, 8'h33, 1, 0, 0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < directed.size(); r++) begin
			row = directed[r];
			if (row.retype)
				write_type(row.new_type);
			drive_item(row.it, row.typed, row.n_typed, row.typed_acts);
		end

		productive = 0;
		phase = 0;
		while (productive < RANDOM_ITEMS) begin
			if (phase < 8)
				write_type(PHASE_TYPES[phase]);
			else
				write_type(4'($urandom_range(0, 15)));
			phase++;
			goal = productive + PHASE_ITEMS;
			while (productive < goal && productive < RANDOM_ITEMS)
				random_request();
		end

		drain_block();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
